// ===== rtl/core/rc_pulse_capture_mode_select_macros.svh =====
// Assertion helpers for the checker file.
`ifndef RC_PULSE_CAPTURE_MODE_SELECT_MACROS_SVH
`define RC_PULSE_CAPTURE_MODE_SELECT_MACROS_SVH

// Clocked property, ignored while reset is held.
`define RCPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked property that is also checked during reset.
`define RCPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/core/rcpc_pkg.sv =====
package rcpc_pkg;

  // Item selectors
  typedef enum logic [1:0] {
    ACT_EDGE = 2'd0,
    ACT_CMD  = 2'd1,
    ACT_TICK = 2'd2
  } rcpc_act_e;

  typedef enum logic [1:0] {
    CH_STEER    = 2'd0,
    CH_THROTTLE = 2'd1,
    CH_SWITCH   = 2'd2
  } rcpc_chan_e;

  typedef enum logic [1:0] {
    MODE_LOCK   = 2'd0,
    MODE_RADIO  = 2'd1,
    MODE_SERIAL = 2'd2
  } rcpc_mode_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_STEER_MIN    = 3'd0,
    CFG_STEER_MAX    = 3'd1,
    CFG_THROTTLE_MIN = 3'd2,
    CFG_THROTTLE_MAX = 3'd3,
    CFG_LOCK_LEVEL   = 3'd4,
    CFG_RADIO_LEVEL  = 3'd5,
    CFG_SERIAL_LEVEL = 3'd6
  } rcpc_cfg_e;

  // Stage load enables of the serial scaling pipe
  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } rcpc_pipe_en_t;

  // Pulse widths
  localparam logic [11:0] NEUTRAL_US      = 12'd1500;
  localparam logic [13:0] SER_NEUTRAL     = 14'd5000;
  localparam logic [13:0] SW_RESET_US     = 14'd100;
  localparam logic [31:0] SW_MIN_US       = 32'd100;
  localparam logic [31:0] SW_MAX_US       = 32'd10000;

  // Configuration reset values
  localparam logic [10:0] STEER_MIN_RST    = 11'd1000;
  localparam logic [11:0] STEER_MAX_RST    = 12'd2000;
  localparam logic [10:0] THROTTLE_MIN_RST = 11'd1200;
  localparam logic [11:0] THROTTLE_MAX_RST = 12'd2000;
  localparam logic [13:0] LOCK_LEVEL_RST   = 14'd2100;
  localparam logic [13:0] RADIO_LEVEL_RST  = 14'd1500;
  localparam logic [13:0] SERIAL_LEVEL_RST = 14'd900;

  // Serial scaling: floor(d * span / 4999). The product is biased by
  // 4096 * 4999 so the division runs on a non-negative value below 2^26.
  localparam int unsigned          SER_SPAN     = 4999;
  localparam logic [25:0]          DIVISOR      = 26'(SER_SPAN);
  localparam logic signed [27:0]   SCALE_OFFSET = 28'sd20475904;
  localparam logic [19:0]          RECIP_M      = 20'(64'd4294967296 / 64'd4999);
  // quotient minus 4096 plus neutral 1500
  localparam logic [13:0]          QUOT_BIAS    = 14'd2596;
  localparam logic [13:0]          QUOT_TOP     = 14'd6691;

endpackage

// ===== rtl/core/rcpc_scale.sv =====
module rcpc_scale (
  input  logic                  clk_i,
  input  rcpc_pkg::rcpc_pipe_en_t en_i,
  input  logic [13:0]           value_i,
  input  logic [10:0]           lo_i,
  input  logic [11:0]           hi_i,
  output logic [11:0]           pulse_o
);
  import rcpc_pkg::*;

  logic signed [14:0] diff;
  logic signed [12:0] span;
  logic signed [27:0] prod;
  logic signed [27:0] biased;
  logic [25:0]        u_q;
  logic [45:0]        recip_prod;
  logic [13:0]        q0_q;
  logic [25:0]        u2_q;
  logic [25:0]        back;
  logic [25:0]        rem;
  logic [13:0]        quot;
  logic [13:0]        quot_off;

  // Stage 1: signed product around neutral, biased positive
  always_comb begin
    diff = $signed({1'b0, value_i}) - $signed({1'b0, SER_NEUTRAL});
    if (!diff[14]) begin
      span = $signed({1'b0, hi_i}) - $signed({1'b0, NEUTRAL_US});
    end else begin
      span = $signed({1'b0, NEUTRAL_US}) - $signed({2'b00, lo_i});
    end
    prod   = diff * span;
    biased = prod + SCALE_OFFSET;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1_en) begin
      u_q <= biased[25:0];
    end
  end

  // Stage 2: reciprocal estimate, low by at most one
  assign recip_prod = 46'(u_q) * 46'(RECIP_M);

  always_ff @(posedge clk_i) begin
    if (en_i.s2_en) begin
      q0_q <= recip_prod[45:32];
      u2_q <= u_q;
    end
  end

  // Correction, unbias and saturation
  always_comb begin
    back     = 26'(q0_q) * DIVISOR;
    rem      = u2_q - back;
    quot     = (rem >= DIVISOR) ? q0_q + 14'd1 : q0_q;
    quot_off = quot - QUOT_BIAS;
    if (quot < QUOT_BIAS) begin
      pulse_o = 12'd0;
    end else if (quot > QUOT_TOP) begin
      pulse_o = 12'd4095;
    end else begin
      pulse_o = quot_off[11:0];
    end
  end

endmodule

// ===== rtl/core/rc_pulse_capture_mode_select.sv =====
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   action, channel, time_us, cmd_steer, cmd_throttle
// out      output     out_valid_o / out_ready_i mode, steer_pulse_us, throttle_pulse_us
// cfg      input      cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// One item per cycle while the input is not stalled. Edges and serial commands
// update state in the cycle after they are taken into the input register; a
// tick passes from the input register through the product, reciprocal estimate
// and output registers, in that order, to the output. Reset is asynchronous
// and needs no clearing pass. A stalled output lets the pipe fill behind it;
// the input stalls only when every tick stage holds an item.
module rc_pulse_capture_mode_select (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [1:0]  channel_i,
  input  logic [31:0] time_us_i,
  input  logic [13:0] cmd_steer_i,
  input  logic [13:0] cmd_throttle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  mode_o,
  output logic [11:0] steer_pulse_us_o,
  output logic [11:0] throttle_pulse_us_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [13:0] cfg_wdata_i
);
  import rcpc_pkg::*;

  // Configuration
  logic [10:0] steer_min_q, throttle_min_q;
  logic [11:0] steer_max_q, throttle_max_q;
  logic [13:0] lock_level_q, radio_level_q, serial_level_q;

  // Input register
  logic        s0_v_q;
  logic [1:0]  s0_act_q, s0_ch_q;
  logic [31:0] s0_time_q;
  logic [13:0] s0_cs_q, s0_ct_q;

  // Block state
  logic [31:0] last_q [3];
  logic [31:0] last_d [3];
  logic [11:0] steer_w_q, steer_w_d, thr_w_q, thr_w_d;
  logic [13:0] sw_w_q, sw_w_d;
  rcpc_mode_e  mode_q, mode_d;
  logic [13:0] ser_steer_q, ser_steer_d, ser_thr_q, ser_thr_d;

  // Tick pipe
  logic        s1_v_q, s2_v_q, out_v_q;
  rcpc_mode_e  s1_mode_q, s2_mode_q, out_mode_q;
  logic [11:0] s1_steer_q, s1_thr_q, s2_steer_q, s2_thr_q;
  logic [11:0] out_steer_q, out_thr_q;
  logic [11:0] steer_scaled, thr_scaled;
  logic [11:0] tick_steer, tick_thr;

  logic          out_load, s2_load, s1_free, s1_load, s0_adv, s0_is_tick;
  rcpc_pipe_en_t pipe_en;

  // Edge decode
  logic [31:0] last_sel, iv;
  logic        ch_ok, edge_ok;
  logic [13:0] dl, dr, ds;

  // Handshake and stage enables
  always_comb begin
    s0_is_tick = (s0_act_q == ACT_TICK);
    out_load   = s2_v_q && (!out_v_q || out_ready_i);
    s2_load    = s1_v_q && (!s2_v_q || out_load);
    s1_free    = !s1_v_q || s2_load;
    s0_adv     = s0_v_q && (!s0_is_tick || s1_free);
    s1_load    = s0_adv && s0_is_tick;
    in_ready_o = !s0_v_q || s0_adv;
    pipe_en.s1_en = s1_load;
    pipe_en.s2_en = s2_load;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steer_min_q    <= STEER_MIN_RST;
      steer_max_q    <= STEER_MAX_RST;
      throttle_min_q <= THROTTLE_MIN_RST;
      throttle_max_q <= THROTTLE_MAX_RST;
      lock_level_q   <= LOCK_LEVEL_RST;
      radio_level_q  <= RADIO_LEVEL_RST;
      serial_level_q <= SERIAL_LEVEL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEER_MIN:    steer_min_q    <= cfg_wdata_i[10:0];
        CFG_STEER_MAX:    steer_max_q    <= cfg_wdata_i[11:0];
        CFG_THROTTLE_MIN: throttle_min_q <= cfg_wdata_i[10:0];
        CFG_THROTTLE_MAX: throttle_max_q <= cfg_wdata_i[11:0];
        CFG_LOCK_LEVEL:   lock_level_q   <= cfg_wdata_i;
        CFG_RADIO_LEVEL:  radio_level_q  <= cfg_wdata_i;
        CFG_SERIAL_LEVEL: serial_level_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (in_ready_o) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s0_act_q  <= action_i;
      s0_ch_q   <= channel_i;
      s0_time_q <= time_us_i;
      s0_cs_q   <= cmd_steer_i;
      s0_ct_q   <= cmd_throttle_i;
    end
  end

  // Edge timing, mode choice and serial commands
  always_comb begin
    unique case (s0_ch_q)
      CH_STEER:    last_sel = last_q[0];
      CH_THROTTLE: last_sel = last_q[1];
      CH_SWITCH:   last_sel = last_q[2];
      default:     last_sel = '0;
    endcase
    ch_ok   = (s0_ch_q == CH_STEER) || (s0_ch_q == CH_THROTTLE) || (s0_ch_q == CH_SWITCH);
    edge_ok = s0_adv && (s0_act_q == ACT_EDGE) && ch_ok && (s0_time_q > last_sel);
    iv      = s0_time_q - last_sel;

    for (int i = 0; i < 3; i++) begin
      last_d[i] = (edge_ok && s0_ch_q == 2'(i)) ? s0_time_q : last_q[i];
    end

    steer_w_d   = steer_w_q;
    thr_w_d     = thr_w_q;
    sw_w_d      = sw_w_q;
    mode_d      = mode_q;
    ser_steer_d = ser_steer_q;
    ser_thr_d   = ser_thr_q;

    if (edge_ok && s0_ch_q == CH_STEER) begin
      if (iv[15:0] >= {5'd0, steer_min_q} && iv[15:0] <= {4'd0, steer_max_q}) begin
        steer_w_d = iv[11:0];
      end
    end
    if (edge_ok && s0_ch_q == CH_THROTTLE) begin
      if (iv[15:0] >= {5'd0, throttle_min_q} && iv[15:0] <= {4'd0, throttle_max_q}) begin
        thr_w_d = iv[11:0];
      end
    end

    if (edge_ok && s0_ch_q == CH_SWITCH && iv >= SW_MIN_US && iv <= SW_MAX_US) begin
      sw_w_d = iv[13:0];
    end
    dl = (sw_w_d > lock_level_q)   ? sw_w_d - lock_level_q   : lock_level_q - sw_w_d;
    dr = (sw_w_d > radio_level_q)  ? sw_w_d - radio_level_q  : radio_level_q - sw_w_d;
    ds = (sw_w_d > serial_level_q) ? sw_w_d - serial_level_q : serial_level_q - sw_w_d;

    // Nearest level wins; radio first on ties, then serial
    if (edge_ok && s0_ch_q == CH_SWITCH) begin
      priority if (dr <= dl && dr <= ds) begin
        mode_d = MODE_RADIO;
      end else if (ds <= dl && ds <= dr) begin
        if (mode_q != MODE_SERIAL) begin
          ser_steer_d = SER_NEUTRAL;
          ser_thr_d   = SER_NEUTRAL;
        end
        mode_d = MODE_SERIAL;
      end else begin
        mode_d = MODE_LOCK;
      end
    end

    // Serial command, all-zero ignored
    if (s0_adv && s0_act_q == ACT_CMD && (s0_cs_q != '0 || s0_ct_q != '0)) begin
      ser_steer_d = s0_cs_q;
      ser_thr_d   = s0_ct_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q[0]   <= '0;
      last_q[1]   <= '0;
      last_q[2]   <= '0;
      steer_w_q   <= NEUTRAL_US;
      thr_w_q     <= NEUTRAL_US;
      sw_w_q      <= SW_RESET_US;
      mode_q      <= MODE_LOCK;
      ser_steer_q <= SER_NEUTRAL;
      ser_thr_q   <= SER_NEUTRAL;
    end else begin
      last_q      <= last_d;
      steer_w_q   <= steer_w_d;
      thr_w_q     <= thr_w_d;
      sw_w_q      <= sw_w_d;
      mode_q      <= mode_d;
      ser_steer_q <= ser_steer_d;
      ser_thr_q   <= ser_thr_d;
    end
  end

  // Tick: radio passes widths, lock gives neutral; serial filled in at the end
  assign tick_steer = (mode_q == MODE_RADIO) ? steer_w_q : NEUTRAL_US;
  assign tick_thr   = (mode_q == MODE_RADIO) ? thr_w_q   : NEUTRAL_US;

  rcpc_scale u_scale_steer (
    .clk_i   (clk_i),
    .en_i    (pipe_en),
    .value_i (ser_steer_q),
    .lo_i    (steer_min_q),
    .hi_i    (steer_max_q),
    .pulse_o (steer_scaled)
  );

  rcpc_scale u_scale_thr (
    .clk_i   (clk_i),
    .en_i    (pipe_en),
    .value_i (ser_thr_q),
    .lo_i    (throttle_min_q),
    .hi_i    (throttle_max_q),
    .pulse_o (thr_scaled)
  );

  // Tick pipe valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_v_q <= 1'b1;
      end else if (s2_load) begin
        s1_v_q <= 1'b0;
      end
      if (s2_load) begin
        s2_v_q <= 1'b1;
      end else if (out_load) begin
        s2_v_q <= 1'b0;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Tick pipe payload
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_mode_q  <= mode_q;
      s1_steer_q <= tick_steer;
      s1_thr_q   <= tick_thr;
    end
    if (s2_load) begin
      s2_mode_q  <= s1_mode_q;
      s2_steer_q <= s1_steer_q;
      s2_thr_q   <= s1_thr_q;
    end
    if (out_load) begin
      out_mode_q  <= s2_mode_q;
      out_steer_q <= (s2_mode_q == MODE_SERIAL) ? steer_scaled : s2_steer_q;
      out_thr_q   <= (s2_mode_q == MODE_SERIAL) ? thr_scaled   : s2_thr_q;
    end
  end

  assign out_valid_o         = out_v_q;
  assign mode_o              = out_mode_q;
  assign steer_pulse_us_o    = out_steer_q;
  assign throttle_pulse_us_o = out_thr_q;

endmodule

// ===== rtl/core/rcpc_checker.sv =====
`include "rc_pulse_capture_mode_select_macros.svh"

module rcpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  mode_o,
  input logic [11:0] steer_pulse_us_o,
  input logic [11:0] throttle_pulse_us_o
);
  import rcpc_pkg::*;

  // Lock mode always drives neutral on both servos
  `RCPC_ASSERT(a_lock_neutral, out_valid_o && mode_o == MODE_LOCK |-> steer_pulse_us_o == NEUTRAL_US && throttle_pulse_us_o == NEUTRAL_US, "lock result not neutral")

  // A free-flowing output never stalls the input
  `RCPC_ASSERT(a_no_false_stall, out_ready_i |-> in_ready_o, "input stalled with output ready")

  // A stalled result holds
  `RCPC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(mode_o) && $stable(steer_pulse_us_o) && $stable(throttle_pulse_us_o), "stalled result changed")

  // Reset leaves no result pending
  `RCPC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid in reset")

endmodule

bind rc_pulse_capture_mode_select rcpc_checker u_rcpc_checker (.*);
